>>> hdl/scsips_pkg.sv
// Package: types and constants shared by the SCSI initiator phase sequencer.
`default_nettype none
package scsips_pkg;

	// function codes of an input beat
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_INTR  = 1'b1;

	// controller commands
	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_NOP      = 3'd1;
	localparam logic [2:0] CMD_DMAXFER  = 3'd2;
	localparam logic [2:0] CMD_COMPLETE = 3'd3;
	localparam logic [2:0] CMD_MSGACC   = 3'd4;
	localparam logic [2:0] CMD_SELECT   = 3'd5;

	// phase codes held in the high byte of the phase status
	localparam logic [7:0] PH_SELECT   = 8'h00;
	localparam logic [7:0] PH_XFER     = 8'h41;
	localparam logic [7:0] PH_COMPLETE = 8'h46;

	// phase status values
	localparam logic [15:0] PS_NO_CMD   = 16'h1000;
	localparam logic [15:0] PS_XFER     = 16'h4100;
	localparam logic [15:0] PS_COMPLETE = 16'h4600;
	localparam logic [7:0]  PS_MSG_HI   = 8'h60;
	localparam logic [7:0]  PS_SHORT_HI = 8'h30;

	// step/interrupt words seen in select phase
	localparam logic [10:0] INTR_NO_CMD = 11'h218;
	localparam logic [10:0] INTR_SHORT  = 11'h318;
	localparam logic [10:0] INTR_DONE   = 11'h418;

	// bus phase meaning status
	localparam logic [2:0] BUS_STATUS = 3'd3;

	// DMA FIFO depth in words
	localparam logic [7:0] DMA_DEPTH = 8'd32;

	// command block lengths
	localparam logic [3:0] CDB_6  = 4'd6;
	localparam logic [3:0] CDB_10 = 4'd10;
	localparam logic [3:0] CDB_12 = 4'd12;

	typedef struct packed {
		logic        func;
		logic [7:0]  opcode;
		logic        read_dir;
		logic [9:0]  data_length;
		logic [7:0]  chip_status;
		logic [2:0]  seq_step;
		logic [7:0]  intr_flags;
		logic [4:0]  fifo_residue;
		logic [15:0] count_left;
		logic        dma_empty;
		logic [7:0]  dma_level;
		logic [7:0]  fifo_byte;
	} item_t;

	typedef struct packed {
		logic        active;
		logic [15:0] phase_status;
		logic        dir_read;
		logic [3:0]  cdb_len;
		logic [9:0]  xfer_len;
		logic [9:0]  xfer_done;
	} seq_state_t;

	typedef struct packed {
		logic [2:0]  chip_cmd;
		logic [5:0]  pad_words;
		logic        dma_stop;
		logic [15:0] cmd_status;
		logic        finished;
		logic [9:0]  moved_bytes;
		logic        spurious;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/scsips_next.sv
// Next-state and result logic for one beat of the phase sequencer.
`default_nettype none
module scsips_next
	import scsips_pkg::*;
#(
	parameter int MAX_DATA = 512
) (
	input  item_t      item,
	input  seq_state_t cur,
	output seq_state_t nxt,
	output result_t    res
);

	logic [10:0] intr;
	logic [2:0]  bus_phase;
	logic [9:0]  sat_len;
	logic [2:0]  grp;
	logic [7:0]  short_hi;
	logic [9:0]  done_val;
	logic [5:0]  pad_val;
	logic        end_cmd;

	// helpers
	always_comb begin
		intr      = {item.seq_step, item.intr_flags};
		bus_phase = item.chip_status[2:0];
		grp       = item.opcode[7:5];
		sat_len   = ({7'd0, item.data_length} > 17'(MAX_DATA)) ? 10'(MAX_DATA)
			: item.data_length;
		short_hi  = PS_SHORT_HI + {4'd0, cur.cdb_len} - {3'd0, item.fifo_residue};
		done_val  = (item.count_left > {6'd0, cur.xfer_len}) ? 10'd0
			: cur.xfer_len - item.count_left[9:0];
		pad_val   = 6'd0;
		if (cur.dir_read && !item.dma_empty && item.dma_level < DMA_DEPTH)
			pad_val = 6'(DMA_DEPTH - item.dma_level);
	end

	// phase decision
	always_comb begin
		nxt     = cur;
		res     = '0;
		end_cmd = 1'b0;
		if (item.func == FUNC_START) begin
			case (grp)
				3'd0:    nxt.cdb_len = CDB_6;
				3'd1:    nxt.cdb_len = CDB_10;
				default: nxt.cdb_len = CDB_12;
			endcase
			nxt.xfer_len     = sat_len;
			nxt.dir_read     = item.read_dir;
			nxt.phase_status = '0;
			nxt.xfer_done    = '0;
			nxt.active       = 1'b1;
			res.chip_cmd     = CMD_SELECT;
		end else if (!item.chip_status[7]) begin
			res.spurious = 1'b1;
		end else if (!cur.active || item.intr_flags[7]) begin
			// idle interrupt or bus reset
			nxt.active   = 1'b0;
			res.chip_cmd = CMD_NOP;
			res.finished = 1'b1;
		end else begin
			case (cur.phase_status[15:8])
				PH_SELECT: begin
					if (intr == INTR_NO_CMD) begin
						nxt.phase_status = PS_NO_CMD;
						end_cmd = 1'b1;
					end else if (intr == INTR_SHORT) begin
						nxt.phase_status = {short_hi, 8'd0};
						end_cmd = 1'b1;
					end else if (intr != INTR_DONE) begin
						end_cmd = 1'b1;
					end else if (bus_phase == {2'd0, cur.dir_read}) begin
						nxt.phase_status = PS_XFER;
						res.chip_cmd     = CMD_DMAXFER;
					end else if (bus_phase != BUS_STATUS) begin
						nxt.phase_status = PS_XFER;
						end_cmd = 1'b1;
					end else begin
						// straight to status: close the data transfer
						nxt.phase_status = PS_COMPLETE;
						nxt.xfer_done    = done_val;
						res.chip_cmd     = CMD_COMPLETE;
						res.pad_words    = pad_val;
						res.dma_stop     = 1'b1;
					end
				end
				PH_XFER: begin
					nxt.phase_status = PS_COMPLETE;
					nxt.xfer_done    = done_val;
					if (bus_phase != BUS_STATUS) begin
						end_cmd = 1'b1;
					end else begin
						res.chip_cmd  = CMD_COMPLETE;
						res.pad_words = pad_val;
						res.dma_stop  = 1'b1;
					end
				end
				PH_COMPLETE: begin
					nxt.phase_status = {PS_MSG_HI, item.fifo_byte};
					res.chip_cmd     = CMD_MSGACC;
				end
				default: begin
					end_cmd = 1'b1;
				end
			endcase
			if (end_cmd) begin
				nxt.active   = 1'b0;
				res.chip_cmd = CMD_NONE;
				res.finished = 1'b1;
			end
		end
		res.cmd_status  = nxt.phase_status;
		res.moved_bytes = nxt.xfer_done;
	end

endmodule
`default_nettype wire

>>> hdl/scsi_initiator_phase_sequencer.sv
// Top level of the SCSI initiator phase sequencer: input register, state, result register.
`default_nettype none
// One result beat per item beat. An item is taken into the input register,
// evaluated against the sequencer state by a single pass of compare and
// subtract logic, and its result is then registered in the result register
// once that register is free or being drained. A new item
// is accepted every cycle; when the result side stalls, the input register
// holds and item_stall rises until the result register can move.
module scsi_initiator_phase_sequencer
	import scsips_pkg::*;
#(
	parameter int MAX_DATA = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        func,
	input  wire logic [7:0]  opcode,
	input  wire logic        read_dir,
	input  wire logic [9:0]  data_length,
	input  wire logic [7:0]  chip_status,
	input  wire logic [2:0]  seq_step,
	input  wire logic [7:0]  intr_flags,
	input  wire logic [4:0]  fifo_residue,
	input  wire logic [15:0] count_left,
	input  wire logic        dma_empty,
	input  wire logic [7:0]  dma_level,
	input  wire logic [7:0]  fifo_byte,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       chip_cmd,
	output logic [5:0]       pad_words,
	output logic             dma_stop,
	output logic [15:0]      cmd_status,
	output logic             finished,
	output logic [9:0]       moved_bytes,
	output logic             spurious
);

	item_t      item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       res_valid_q;
	logic       advance;

	// pipeline moves when the result register is free or being drained
	assign advance    = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{func, opcode, read_dir, data_length, chip_status, seq_step,
				intr_flags, fifo_residue, count_left, dma_empty, dma_level, fifo_byte};
		end
	end

	scsips_next #(
		.MAX_DATA(MAX_DATA)
	) u_next (
		.item(item_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign chip_cmd     = res_q.chip_cmd;
	assign pad_words    = res_q.pad_words;
	assign dma_stop     = res_q.dma_stop;
	assign cmd_status   = res_q.cmd_status;
	assign finished     = res_q.finished;
	assign moved_bytes  = res_q.moved_bytes;
	assign spurious     = res_q.spurious;

endmodule
`default_nettype wire

>>> verif/scsi_initiator_phase_sequencer_test.sv
// Testbench for the SCSI initiator phase sequencer: directed table, random commands, scoreboard.
`timescale 1ns / 1ps
module scsi_initiator_phase_sequencer_test;
	import scsips_pkg::*;

	localparam logic [9:0] DATA_MAX    = 10'd512;
	localparam int         RANDOM_BEATS = 700;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PAUSE_AT     = 200;
	localparam int         CALM_FROM    = 350;
	localparam int         CALM_TO      = 500;

	typedef struct {
		item_t   it;
		bit      known;
		result_t res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        func = 1'b0;
	logic [7:0]  opcode = '0;
	logic        read_dir = 1'b0;
	logic [9:0]  data_length = '0;
	logic [7:0]  chip_status = '0;
	logic [2:0]  seq_step = '0;
	logic [7:0]  intr_flags = '0;
	logic [4:0]  fifo_residue = '0;
	logic [15:0] count_left = '0;
	logic        dma_empty = 1'b0;
	logic [7:0]  dma_level = '0;
	logic [7:0]  fifo_byte = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  chip_cmd;
	logic [5:0]  pad_words;
	logic        dma_stop;
	logic [15:0] cmd_status;
	logic        finished;
	logic [9:0]  moved_bytes;
	logic        spurious;

	// predictor state and scoreboard
	seq_state_t tracked = '0;
	result_t    phase_results_due[$];
	result_t    oldest_due;
	int         mismatch_count = 0;
	int         beats_sent = 0;
	int         beats_goal = 0;
	int         cycles = 0;
	bit         calm = 1'b0;

	scsi_initiator_phase_sequencer DUT (.*);

	always #2 clk = ~clk;

	// expected outcome of one beat; updates the tracked sequencer state
	function automatic result_t next_phase_result(item_t it);
		result_t    r;
		logic [10:0] intr;
		logic [2:0] bus_ph;
		logic [2:0] grp;
		logic [7:0] short_hi;
		bit         xfer_end;
		bit         ends;
		r = '0;
		if (it.func == FUNC_START) begin
			grp = it.opcode[7:5];
			tracked.cdb_len = (grp == 3'd0) ? CDB_6 : (grp == 3'd1) ? CDB_10 : CDB_12;
			tracked.xfer_len = (it.data_length > DATA_MAX) ? DATA_MAX : it.data_length;
			tracked.dir_read = it.read_dir;
			tracked.phase_status = '0;
			tracked.xfer_done = '0;
			tracked.active = 1'b1;
			r.chip_cmd = CMD_SELECT;
		end else if (!it.chip_status[7]) begin
			r.spurious = 1'b1;
		end else if (!tracked.active || it.intr_flags[7]) begin
			// idle or bus reset: nop, status kept
			tracked.active = 1'b0;
			r.chip_cmd = CMD_NOP;
			r.finished = 1'b1;
		end else begin
			intr = {it.seq_step, it.intr_flags};
			bus_ph = it.chip_status[2:0];
			xfer_end = 1'b0;
			ends = 1'b1;
			case (tracked.phase_status[15:8])
				PH_SELECT: begin
					if (intr == INTR_NO_CMD) begin
						tracked.phase_status = PS_NO_CMD;
					end else if (intr == INTR_SHORT) begin
						short_hi = PS_SHORT_HI + 8'(tracked.cdb_len) - 8'(it.fifo_residue);
						tracked.phase_status = {short_hi, 8'h00};
					end else if (intr == INTR_DONE) begin
						tracked.phase_status = PS_XFER;
						if (bus_ph == {2'b00, tracked.dir_read}) begin
							r.chip_cmd = CMD_DMAXFER;
							ends = 1'b0;
						end else if (bus_ph == BUS_STATUS) begin
							xfer_end = 1'b1;
						end
					end
				end
				PH_XFER: xfer_end = 1'b1;
				PH_COMPLETE: begin
					tracked.phase_status = {PS_MSG_HI, it.fifo_byte};
					r.chip_cmd = CMD_MSGACC;
					ends = 1'b0;
				end
				default: ;
			endcase
			// end of data transfer, count saturates at zero
			if (xfer_end) begin
				tracked.phase_status = PS_COMPLETE;
				tracked.xfer_done = (it.count_left > 16'(tracked.xfer_len)) ? '0 :
					tracked.xfer_len - it.count_left[9:0];
				if (bus_ph == BUS_STATUS) begin
					r.chip_cmd = CMD_COMPLETE;
					r.dma_stop = 1'b1;
					ends = 1'b0;
					if (tracked.dir_read && !it.dma_empty && it.dma_level < DMA_DEPTH)
						r.pad_words = 6'(DMA_DEPTH - it.dma_level);
				end
			end
			if (ends) begin
				tracked.active = 1'b0;
				r.finished = 1'b1;
			end
		end
		r.cmd_status = tracked.phase_status;
		r.moved_bytes = tracked.xfer_done;
		return r;
	endfunction

	function automatic item_t start_beat(logic [7:0] op, logic rd, logic [9:0] len);
		item_t b;
		b = '0;
		b.func = FUNC_START;
		b.opcode = op;
		b.read_dir = rd;
		b.data_length = len;
		return b;
	endfunction

	function automatic item_t intr_beat(logic [7:0] cst, logic [2:0] step, logic [7:0] flg,
			logic [4:0] resid, logic [15:0] cnt, logic empty, logic [7:0] level,
			logic [7:0] fbyte);
		item_t b;
		b = '0;
		b.func = FUNC_INTR;
		b.chip_status = cst;
		b.seq_step = step;
		b.intr_flags = flg;
		b.fifo_residue = resid;
		b.count_left = cnt;
		b.dma_empty = empty;
		b.dma_level = level;
		b.fifo_byte = fbyte;
		return b;
	endfunction

	function automatic result_t res_of(logic [2:0] cmd, logic [5:0] pad, logic stop,
			logic [15:0] status, logic fin, logic [9:0] moved, logic spur);
		result_t r;
		r.chip_cmd = cmd;
		r.pad_words = pad;
		r.dma_stop = stop;
		r.cmd_status = status;
		r.finished = fin;
		r.moved_bytes = moved;
		r.spurious = spur;
		return r;
	endfunction

	function automatic row_t row(item_t it, bit known, result_t res);
		row_t r;
		r.it = it;
		r.known = known;
		r.res = res;
		return r;
	endfunction

	function automatic item_t rand_beat();
		item_t b;
		b.func = 1'($urandom);
		b.opcode = 8'($urandom);
		b.read_dir = 1'($urandom);
		b.data_length = 10'($urandom);
		b.chip_status = 8'($urandom);
		b.seq_step = 3'($urandom);
		b.intr_flags = 8'($urandom);
		b.fifo_residue = 5'($urandom);
		b.count_left = 16'($urandom);
		b.dma_empty = 1'($urandom);
		b.dma_level = ($urandom_range(99) < 50) ? 8'($urandom_range(40)) : 8'($urandom);
		b.fifo_byte = 8'($urandom);
		return b;
	endfunction

	// drive one item beat from a falling edge, predict it at the accepting edge
	task automatic send_beat(item_t it, bit known, result_t typed);
		int      gap;
		result_t due;
		gap = 0;
		if (!calm && $urandom_range(99) < 15)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		{func, opcode, read_dir, data_length, chip_status, seq_step, intr_flags,
			fifo_residue, count_left, dma_empty, dma_level, fifo_byte} <= it;
		do @(posedge clk); while (item_stall);
		due = next_phase_result(it);
		phase_results_due.push_back(known ? typed : due);
		beats_sent++;
		@(negedge clk);
	endtask

	// one command: start, then interrupts shaped for the phase being waited on
	task automatic run_command();
		item_t b;
		int    r;
		b = rand_beat();
		b.func = FUNC_START;
		if ($urandom_range(99) < 80)
			b.data_length = 10'($urandom_range(512));
		send_beat(b, 1'b0, '0);
		while (tracked.active && beats_sent < beats_goal) begin
			b = rand_beat();
			b.func = FUNC_INTR;
			b.chip_status[7] = 1'b1;
			b.intr_flags[7] = 1'b0;
			case (tracked.phase_status[15:8])
				PH_SELECT: begin
					r = $urandom_range(99);
					if (r < 70) begin
						{b.seq_step, b.intr_flags} = INTR_DONE;
						r = $urandom_range(99);
						if (r < 60)
							b.chip_status[2:0] = {2'b00, tracked.dir_read};
						else if (r < 85)
							b.chip_status[2:0] = BUS_STATUS;
					end else if (r < 80) begin
						{b.seq_step, b.intr_flags} = INTR_NO_CMD;
					end else if (r < 90) begin
						{b.seq_step, b.intr_flags} = INTR_SHORT;
					end
				end
				PH_XFER: begin
					if ($urandom_range(99) < 80)
						b.chip_status[2:0] = BUS_STATUS;
					if ($urandom_range(99) < 85)
						b.count_left = 16'($urandom_range(int'(tracked.xfer_len)));
				end
				default: ;
			endcase
			// noise: not pending, bus reset, restart while busy
			r = $urandom_range(99);
			if (r < 8)
				b.chip_status[7] = 1'b0;
			else if (r < 11)
				b.intr_flags[7] = 1'b1;
			else if (r < 14)
				b.func = FUNC_START;
			send_beat(b, 1'b0, '0);
		end
	endtask

	// note one field mismatch
	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// result receiver stalls at random except in the calm stretch
	always @(negedge clk)
		result_stall <= arst_n && !calm && ($urandom_range(99) < 15);

	// scoreboard: every result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (phase_results_due.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual cmd 0x%0h status 0x%0h",
					$time, chip_cmd, cmd_status);
				mismatch_count++;
			end else begin
				oldest_due = phase_results_due.pop_front();
				check_field("chip_cmd", oldest_due.chip_cmd, chip_cmd);
				check_field("pad_words", oldest_due.pad_words, pad_words);
				check_field("dma_stop", oldest_due.dma_stop, dma_stop);
				check_field("cmd_status", oldest_due.cmd_status, cmd_status);
				check_field("finished", oldest_due.finished, finished);
				check_field("moved_bytes", oldest_due.moved_bytes, moved_bytes);
				check_field("spurious", oldest_due.spurious, spurious);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		row_t plan[$];
		item_t b;
		bit paused;
		paused = 1'b0;

		// directed table
		plan.push_back(row(intr_beat(8'h7f, 3'd7, 8'hff, 5'd31, 16'hffff, 1'b1, 8'hff, 8'hff),
			1'b1, res_of(CMD_NONE, 6'd0, 1'b0, 16'h0000, 1'b0, 10'd0, 1'b1)));
		plan.push_back(row(intr_beat(8'h80, 3'd0, 8'h00, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b1, res_of(CMD_NOP, 6'd0, 1'b0, 16'h0000, 1'b1, 10'd0, 1'b0)));
		// oversized length saturates, read command runs end to end
		plan.push_back(row(start_beat(8'h00, 1'b1, 10'h3ff),
			1'b1, res_of(CMD_SELECT, 6'd0, 1'b0, 16'h0000, 1'b0, 10'd0, 1'b0)));
		plan.push_back(row(intr_beat(8'h81, 3'd4, 8'h18, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b1, res_of(CMD_DMAXFER, 6'd0, 1'b0, PS_XFER, 1'b0, 10'd0, 1'b0)));
		plan.push_back(row(intr_beat(8'h83, 3'd0, 8'h00, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b1, res_of(CMD_COMPLETE, 6'd32, 1'b1, PS_COMPLETE, 1'b0, DATA_MAX, 1'b0)));
		plan.push_back(row(intr_beat(8'h80, 3'd0, 8'h00, 5'd0, 16'h0, 1'b0, 8'h00, 8'hff),
			1'b1, res_of(CMD_MSGACC, 6'd0, 1'b0, {PS_MSG_HI, 8'hff}, 1'b0, DATA_MAX, 1'b0)));
		// unknown phase code ends the command
		plan.push_back(row(intr_beat(8'h80, 3'd0, 8'h00, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b1, res_of(CMD_NONE, 6'd0, 1'b0, {PS_MSG_HI, 8'hff}, 1'b1, DATA_MAX, 1'b0)));
		// short command with the widest residue
		plan.push_back(row(start_beat(8'h20, 1'b0, 10'd0),
			1'b1, res_of(CMD_SELECT, 6'd0, 1'b0, 16'h0000, 1'b0, 10'd0, 1'b0)));
		plan.push_back(row(intr_beat(8'h80, 3'd3, 8'h18, 5'd31, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		// no command phase
		plan.push_back(row(start_beat(8'hff, 1'b0, DATA_MAX),
			1'b1, res_of(CMD_SELECT, 6'd0, 1'b0, 16'h0000, 1'b0, 10'd0, 1'b0)));
		plan.push_back(row(intr_beat(8'h80, 3'd2, 8'h18, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b1, res_of(CMD_NONE, 6'd0, 1'b0, PS_NO_CMD, 1'b1, 10'd0, 1'b0)));
		// select straight into status phase, count above length
		plan.push_back(row(start_beat(8'h40, 1'b0, 10'd100), 1'b0, '0));
		plan.push_back(row(intr_beat(8'h83, 3'd4, 8'h18, 5'd0, 16'hffff, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		plan.push_back(row(intr_beat(8'h80, 3'd0, 8'h00, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		// select done in a wrong bus phase
		plan.push_back(row(start_beat(8'h60, 1'b1, 10'd200), 1'b0, '0));
		plan.push_back(row(intr_beat(8'h82, 3'd4, 8'h18, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		// transfer ends outside status phase
		plan.push_back(row(start_beat(8'h9f, 1'b0, 10'd300), 1'b0, '0));
		plan.push_back(row(intr_beat(8'h80, 3'd4, 8'h18, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		plan.push_back(row(intr_beat(8'h87, 3'd0, 8'h00, 5'd0, 16'd100, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		// start while busy, then bus reset
		plan.push_back(row(start_beat(8'h3f, 1'b1, 10'd64), 1'b0, '0));
		plan.push_back(row(intr_beat(8'h81, 3'd4, 8'h18, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b0, '0));
		plan.push_back(row(start_beat(8'hc0, 1'b1, DATA_MAX), 1'b0, '0));
		plan.push_back(row(intr_beat(8'h80, 3'd4, 8'h98, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b1, res_of(CMD_NOP, 6'd0, 1'b0, 16'h0000, 1'b1, 10'd0, 1'b0)));
		// unknown interrupt in select phase
		plan.push_back(row(start_beat(8'h1f, 1'b1, DATA_MAX), 1'b0, '0));
		plan.push_back(row(intr_beat(8'h80, 3'd1, 8'h10, 5'd0, 16'h0, 1'b0, 8'h00, 8'h00),
			1'b0, '0));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_beat(plan[i].it, plan[i].known, plan[i].res);

		// random commands with stray beats between them
		beats_goal = beats_sent + RANDOM_BEATS;
		while (beats_sent < beats_goal) begin
			calm = (beats_sent >= CALM_FROM && beats_sent < CALM_TO);
			if (!paused && beats_sent >= PAUSE_AT) begin
				// hold off until the sequencer has drained
				paused = 1'b1;
				item_valid <= 1'b0;
				do @(negedge clk); while (phase_results_due.size() != 0);
			end
			if ($urandom_range(99) < 6) begin
				b = rand_beat();
				send_beat(b, 1'b0, '0);
			end else begin
				run_command();
			end
		end
		calm = 1'b0;
		item_valid <= 1'b0;

		while (phase_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
